[rtl/i2cee_pkg.sv]
// i2cee_pkg: shared types and constants for the I2C EEPROM transfer sequencer.
// No dependencies; imported by every module of the block.
`default_nettype none

package i2cee_pkg;

	localparam int PAGE_BYTES = 64;
	localparam int PAGE_BITS  = $clog2(PAGE_BYTES);
	localparam int QDEPTH     = 4;
	localparam int QW         = $clog2(QDEPTH);

	localparam logic [6:0] DEV_ADDR_RST = 7'd80;
	localparam logic [7:0] WAIT_MS_RST  = 8'd6;

	typedef enum logic {
		REG_DEVICE_ADDRESS = 1'b0,
		REG_WRITE_WAIT_MS  = 1'b1
	} reg_idx_t;

	typedef enum logic [1:0] {
		OP_RD     = 2'd0,
		OP_WR     = 2'd1,
		OP_STATUS = 2'd2,
		OP_WBYTE  = 2'd3
	} op_t;

	typedef enum logic [2:0] {
		ST_START  = 3'd0,
		ST_REP    = 3'd1,
		ST_TXADDR = 3'd2,
		ST_TXDATA = 3'd3,
		ST_RXADDR = 3'd4,
		ST_RXACK  = 3'd5,
		ST_RXNACK = 3'd6,
		ST_OTHER  = 3'd7
	} st_t;

	typedef enum logic [3:0] {
		ACT_START = 4'd0,
		ACT_SEND  = 4'd1,
		ACT_RACK  = 4'd2,
		ACT_RNACK = 4'd3,
		ACT_STOP  = 4'd4,
		ACT_WAIT  = 4'd5,
		ACT_DATA  = 4'd6,
		ACT_OK    = 4'd7,
		ACT_ERR   = 4'd8,
		ACT_NEED  = 4'd9
	} act_t;

	typedef enum logic [3:0] {
		PH_IDLE  = 4'd0,
		PH_START = 4'd1,
		PH_DEVW  = 4'd2,
		PH_HI    = 4'd3,
		PH_LO    = 4'd4,
		PH_REP   = 4'd5,
		PH_DEVR  = 4'd6,
		PH_RDATA = 4'd7,
		PH_WNEED = 4'd8,
		PH_WDATA = 4'd9
	} phase_t;

	// Up to three results caused by one item. Only send, data out and wait
	// carry a byte, and a group holds at most one of them.
	typedef struct packed {
		logic [1:0] n;
		act_t       a0;
		act_t       a1;
		act_t       a2;
		logic [7:0] data;
	} grp_t;

endpackage

`default_nettype wire

[rtl/i2cee_req_if.sv]
// i2cee_req_if: input channel of the sequencer (commands, bus replies, host bytes).
// Standalone; valid/ready handshake.
`default_nettype none

interface i2cee_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  opcode;
	logic [15:0] mem_address;
	logic [15:0] length;
	logic [2:0]  bus_status;
	logic [7:0]  read_byte;
	logic [7:0]  write_byte;

	modport source(output valid, output opcode, output mem_address, output length,
		output bus_status, output read_byte, output write_byte, input ready);
	modport sink(input valid, input opcode, input mem_address, input length,
		input bus_status, input read_byte, input write_byte, output ready);
endinterface

`default_nettype wire

[rtl/i2cee_rsp_if.sv]
// i2cee_rsp_if: result channel of the sequencer (bus actions, data out, status).
// Standalone; valid/ready handshake.
`default_nettype none

interface i2cee_rsp_if;
	logic       valid;
	logic       ready;
	logic [3:0] action;
	logic [7:0] out_byte;
	logic       last;

	modport source(output valid, output action, output out_byte, output last, input ready);
	modport sink(input valid, input action, input out_byte, input last, output ready);
endinterface

`default_nettype wire

[rtl/i2c_eeprom_transfer_sequencer.sv]
// i2c_eeprom_transfer_sequencer: top level; configuration registers and the
// front / queue / back parts. Depends on i2cee_pkg, i2cee_req_if, i2cee_rsp_if,
// i2cee_front, i2cee_queue, i2cee_back.
//
// Usage: the req channel carries begin-read / begin-write commands, bus status
// replies (with the received byte) and host write bytes. The rsp channel returns
// bus actions (start, send, ack/nack read, stop, wait), read data and ok/error,
// with last set on the final result caused by each item.
// Timing: an item is classified in the cycle it is accepted; its results reach rsp
// behind those of earlier items, one per cycle while rsp is ready (at most three per item).
// Throughput: one item per cycle while the four-entry group queue has room; the
// back end drains one result per cycle while rsp is ready, so sustained rate is set by
// the number of results per item.
// Reset: transfer state goes idle, queue empties, device address returns to 80
// and page-write wait to 6 ms. A stalled rsp holds its result; req keeps being
// accepted until the queue is full.
`default_nettype none

module i2c_eeprom_transfer_sequencer import i2cee_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       cfg_we,
	input  logic       cfg_index,
	input  logic [7:0] cfg_data,
	i2cee_req_if.sink  req,
	i2cee_rsp_if.source rsp
);

	logic [6:0] dev_addr_q;
	logic [7:0] wait_ms_q;
	logic       push, pop, q_full, q_empty;
	grp_t       push_grp, head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dev_addr_q <= DEV_ADDR_RST;
			wait_ms_q  <= WAIT_MS_RST;
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_DEVICE_ADDRESS: dev_addr_q <= cfg_data[6:0];
				REG_WRITE_WAIT_MS:  wait_ms_q  <= cfg_data;
			endcase
		end
	end

	i2cee_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.dev_addr (dev_addr_q),
		.wait_ms  (wait_ms_q),
		.req      (req),
		.q_full   (q_full),
		.push     (push),
		.grp      (push_grp)
	);

	i2cee_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_grp (push_grp),
		.pop      (pop),
		.head     (head),
		.full     (q_full),
		.empty    (q_empty)
	);

	i2cee_back u_back (
		.clk    (clk),
		.arst_n (arst_n),
		.head   (head),
		.empty  (q_empty),
		.pop    (pop),
		.rsp    (rsp)
	);

endmodule

`default_nettype wire

[rtl/i2cee_front.sv]
// i2cee_front: accepts items, runs the transfer state machine and builds result groups.
// Depends on i2cee_pkg and i2cee_req_if.
`default_nettype none

module i2cee_front import i2cee_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	input  logic [6:0] dev_addr,
	input  logic [7:0] wait_ms,
	i2cee_req_if.sink  req,
	input  logic       q_full,
	output logic       push,
	output grp_t       grp
);

	phase_t      phase_q, phase_d;
	logic        writing_q;
	logic [15:0] cur_q, done_q, total_q;

	logic        fire;
	op_t         op;
	st_t         st;
	logic        is_begin, is_status, st_ok;
	logic [15:0] cur_inc, done_inc;
	logic        rd_last_now, rd_last_next, all_done, page_end;

	assign req.ready = !q_full;
	assign fire      = req.valid && req.ready;
	assign op        = op_t'(req.opcode);
	assign st        = st_t'(req.bus_status);
	assign is_begin  = (op == OP_RD) || (op == OP_WR);
	assign is_status = (op == OP_STATUS);

	assign cur_inc      = cur_q + 16'd1;
	assign done_inc     = done_q + 16'd1;
	assign rd_last_now  = ({1'b0, done_q} + 17'd1) >= {1'b0, total_q};
	assign rd_last_next = ({1'b0, done_inc} + 17'd1) >= {1'b0, total_q};
	assign all_done     = done_inc >= total_q;
	assign page_end     = cur_inc[PAGE_BITS-1:0] == '0;

	// expected bus status for the current phase
	always_comb begin
		unique case (phase_q)
			PH_START:                st_ok = (st == ST_START);
			PH_DEVW:                 st_ok = (st == ST_TXADDR);
			PH_HI, PH_LO, PH_WDATA:  st_ok = (st == ST_TXDATA);
			PH_REP:                  st_ok = (st == ST_REP);
			PH_DEVR:                 st_ok = (st == ST_RXADDR);
			PH_RDATA:                st_ok = (st == (rd_last_now ? ST_RXNACK : ST_RXACK));
			default:                 st_ok = 1'b0;
		endcase
	end

	// next state
	always_comb begin
		phase_d = phase_q;
		unique case (op) inside
			OP_RD, OP_WR: begin
				if (phase_q == PH_IDLE)
					phase_d = (op == OP_WR && req.length == 16'd0) ? PH_IDLE : PH_START;
			end
			OP_STATUS: begin
				if (phase_q != PH_IDLE) begin
					if (!st_ok) begin
						phase_d = PH_IDLE;
					end else begin
						unique case (phase_q)
							PH_START: phase_d = PH_DEVW;
							PH_DEVW:  phase_d = PH_HI;
							PH_HI:    phase_d = PH_LO;
							PH_LO:    phase_d = writing_q ? PH_WNEED : PH_REP;
							PH_REP:   phase_d = PH_DEVR;
							PH_DEVR:  phase_d = (total_q == 16'd0) ? PH_IDLE : PH_RDATA;
							PH_RDATA: phase_d = all_done ? PH_IDLE : PH_RDATA;
							PH_WDATA: phase_d = all_done ? PH_IDLE :
								(page_end ? PH_START : PH_WNEED);
							default:  phase_d = PH_IDLE;
						endcase
					end
				end
			end
			OP_WBYTE: begin
				if (phase_q == PH_WNEED)
					phase_d = PH_WDATA;
			end
		endcase
	end

	// result group
	always_comb begin
		grp.n    = 2'd0;
		grp.a0   = ACT_OK;
		grp.a1   = ACT_OK;
		grp.a2   = ACT_OK;
		grp.data = 8'd0;
		unique case (op) inside
			OP_RD, OP_WR: begin
				if (phase_q == PH_IDLE) begin
					grp.n  = 2'd1;
					grp.a0 = (op == OP_WR && req.length == 16'd0) ? ACT_OK : ACT_START;
				end
			end
			OP_STATUS: begin
				if (phase_q != PH_IDLE) begin
					grp.n = 2'd1;
					if (!st_ok) begin
						grp.a0 = ACT_ERR;
					end else begin
						unique case (phase_q)
							PH_START: begin
								grp.a0   = ACT_SEND;
								grp.data = {dev_addr, 1'b0};
							end
							PH_DEVW: begin
								grp.a0   = ACT_SEND;
								grp.data = cur_q[15:8];
							end
							PH_HI: begin
								grp.a0   = ACT_SEND;
								grp.data = cur_q[7:0];
							end
							PH_LO: grp.a0 = writing_q ? ACT_NEED : ACT_START;
							PH_REP: begin
								grp.a0   = ACT_SEND;
								grp.data = {dev_addr, 1'b1};
							end
							PH_DEVR: begin
								if (total_q == 16'd0) begin
									grp.n  = 2'd2;
									grp.a0 = ACT_STOP;
									grp.a1 = ACT_OK;
								end else begin
									grp.a0 = rd_last_now ? ACT_RNACK : ACT_RACK;
								end
							end
							PH_RDATA: begin
								grp.a0   = ACT_DATA;
								grp.data = req.read_byte;
								if (all_done) begin
									grp.n  = 2'd3;
									grp.a1 = ACT_STOP;
									grp.a2 = ACT_OK;
								end else begin
									grp.n  = 2'd2;
									grp.a1 = rd_last_next ? ACT_RNACK : ACT_RACK;
								end
							end
							PH_WDATA: begin
								if (all_done || page_end) begin
									grp.n    = 2'd3;
									grp.a0   = ACT_STOP;
									grp.a1   = ACT_WAIT;
									grp.a2   = all_done ? ACT_OK : ACT_START;
									grp.data = wait_ms;
								end else begin
									grp.a0 = ACT_NEED;
								end
							end
							default: grp.a0 = ACT_ERR;
						endcase
					end
				end
			end
			OP_WBYTE: begin
				if (phase_q == PH_WNEED) begin
					grp.n    = 2'd1;
					grp.a0   = ACT_SEND;
					grp.data = req.write_byte;
				end
			end
		endcase
	end

	assign push = fire && (grp.n != 2'd0);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q   <= PH_IDLE;
			writing_q <= 1'b0;
			cur_q     <= 16'd0;
			done_q    <= 16'd0;
			total_q   <= 16'd0;
		end else if (fire) begin
			phase_q <= phase_d;
			if (is_begin && phase_q == PH_IDLE) begin
				writing_q <= (op == OP_WR);
				cur_q     <= req.mem_address;
				total_q   <= req.length;
				done_q    <= 16'd0;
			end else if (is_status && st_ok && (phase_q == PH_RDATA || phase_q == PH_WDATA)) begin
				cur_q  <= cur_inc;
				done_q <= done_inc;
			end
		end
	end

	a_idle_status_silent: assert property (@(posedge clk) disable iff (!arst_n)
		fire && is_status && phase_q == PH_IDLE |-> !push)
		else $error("status reply while idle produced results");

	a_error_to_idle: assert property (@(posedge clk) disable iff (!arst_n)
		push && grp.a0 == ACT_ERR |=> phase_q == PH_IDLE)
		else $error("error result did not end the transfer");

	a_byte_to_wdata: assert property (@(posedge clk) disable iff (!arst_n)
		fire && op == OP_WBYTE && phase_q == PH_WNEED |=> phase_q == PH_WDATA)
		else $error("host byte did not advance to write data phase");

endmodule

`default_nettype wire

[rtl/i2cee_queue.sv]
// i2cee_queue: short queue of result groups between the front and back parts.
// Depends on i2cee_pkg.
`default_nettype none

module i2cee_queue import i2cee_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  grp_t push_grp,
	input  logic pop,
	output grp_t head,
	output logic full,
	output logic empty
);

	grp_t          mem_q [QDEPTH];
	logic [QW-1:0] wr_ptr_q, rd_ptr_q;
	logic [QW:0]   cnt_q;

	assign full  = cnt_q == QDEPTH[QW:0];
	assign empty = cnt_q == '0;
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			mem_q[wr_ptr_q] <= push_grp;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("push into full queue");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("pop from empty queue");

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= QDEPTH[QW:0])
		else $error("queue count beyond depth");

endmodule

`default_nettype wire

[rtl/i2cee_back.sv]
// i2cee_back: unpacks queued result groups onto the result channel, one result per cycle while rsp is ready.
// Depends on i2cee_pkg and i2cee_rsp_if.
`default_nettype none

module i2cee_back import i2cee_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  grp_t        head,
	input  logic        empty,
	output logic        pop,
	i2cee_rsp_if.source rsp
);

	logic [1:0] idx_q;
	act_t       act;
	logic       is_last;

	always_comb begin
		case (idx_q)
			2'd0:    act = head.a0;
			2'd1:    act = head.a1;
			default: act = head.a2;
		endcase
	end

	assign is_last      = (idx_q == head.n - 2'd1);
	assign rsp.valid    = !empty;
	assign rsp.action   = act;
	assign rsp.out_byte = (act == ACT_SEND || act == ACT_DATA || act == ACT_WAIT) ?
		head.data : 8'd0;
	assign rsp.last     = is_last;
	assign pop          = rsp.valid && rsp.ready && is_last;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			idx_q <= 2'd0;
		else if (rsp.valid && rsp.ready)
			idx_q <= is_last ? 2'd0 : idx_q + 2'd1;
	end

	a_group_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> head.n != 2'd0)
		else $error("empty result group in queue");

	a_idx_in_group: assert property (@(posedge clk) disable iff (!arst_n)
		rsp.valid |-> idx_q < head.n)
		else $error("result index beyond group size");

	a_idx_reset_after_pop: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == 2'd0)
		else $error("result index not rewound after group");

endmodule

`default_nettype wire

[tb/sv/tb_i2c_eeprom_transfer_sequencer.sv]
// Self-checking testbench for the I2C EEPROM transfer sequencer: directed and random
// command / bus-reply streams, a behavioral predictor and an in-order result checker.
// Depends on i2cee_pkg, i2cee_req_if, i2cee_rsp_if and i2c_eeprom_transfer_sequencer.

module tb_i2c_eeprom_transfer_sequencer;
	import i2cee_pkg::*;

	localparam int HOLD_CYCLES   = 300;
	localparam int SETTLE_CYCLES = 8;
	localparam int DRAIN_LIMIT   = 4000;
	localparam int RUN_LIMIT     = 400000;

	typedef struct {
		act_t       action;
		logic [7:0] out_byte;
		logic       last;
	} bus_action_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       cfg_we;
	reg_idx_t   cfg_index;
	logic [7:0] cfg_data;

	i2cee_req_if req_ch();
	i2cee_rsp_if rsp_ch();

	i2c_eeprom_transfer_sequencer DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// predicted block state and register copies
	phase_t      prd_phase;
	logic        prd_writing;
	logic [15:0] prd_addr;
	logic [15:0] prd_done;
	logic [15:0] prd_total;
	logic [6:0]  cfg_dev;
	logic [7:0]  cfg_wait;

	bus_action_t pending_actions[$];

	int  fail_count = 0;
	int  items_sent = 0;
	int  results_checked = 0;
	int  results_of_last = 0;
	int  begins_taken = 0;
	int  bus_errors = 0;
	bit  no_idle = 1'b0;
	logic hold_active = 1'b0;
	event hold_kick;

	function automatic void flag_error(string msg);
		if (fail_count < 10)
			$display("%s", msg);
		fail_count++;
	endfunction

	function automatic void push_action(act_t a, logic [7:0] b);
		pending_actions.push_back('{action: a, out_byte: b, last: 1'b0});
	endfunction

	function automatic bit final_read_next();
		return int'(prd_done) + 1 >= int'(prd_total);
	endfunction

	// status the sequencer is waiting for in its current phase
	function automatic st_t wanted_status();
		case (prd_phase)
			PH_START:                 return ST_START;
			PH_DEVW:                  return ST_TXADDR;
			PH_HI, PH_LO, PH_WDATA:   return ST_TXDATA;
			PH_REP:                   return ST_REP;
			PH_DEVR:                  return ST_RXADDR;
			PH_RDATA:                 return final_read_next() ? ST_RXNACK : ST_RXACK;
			default:                  return ST_OTHER;
		endcase
	endfunction

	function automatic int predict_actions(op_t op, logic [15:0] addr, logic [15:0] len,
			st_t st, logic [7:0] rb, logic [7:0] wb);
		int         first;
		logic [7:0] dev;
		first = pending_actions.size();
		dev = {cfg_dev, 1'b0};
		case (op)
			OP_RD, OP_WR: begin
				if (prd_phase == PH_IDLE) begin
					begins_taken++;
					prd_writing = (op == OP_WR);
					prd_addr = addr;
					prd_total = len;
					prd_done = '0;
					if (prd_writing && len == 16'd0) begin
						push_action(ACT_OK, 8'h00);
					end else begin
						push_action(ACT_START, 8'h00);
						prd_phase = PH_START;
					end
				end
			end
			OP_STATUS: begin
				if (prd_phase == PH_IDLE) begin
					// bus reply with no transfer open: dropped
				end else if (prd_phase == PH_WNEED || st != wanted_status()) begin
					bus_errors++;
					push_action(ACT_ERR, 8'h00);
					prd_phase = PH_IDLE;
				end else begin
					case (prd_phase)
						PH_START: begin
							push_action(ACT_SEND, dev);
							prd_phase = PH_DEVW;
						end
						PH_DEVW: begin
							push_action(ACT_SEND, prd_addr[15:8]);
							prd_phase = PH_HI;
						end
						PH_HI: begin
							push_action(ACT_SEND, prd_addr[7:0]);
							prd_phase = PH_LO;
						end
						PH_LO: begin
							if (prd_writing) begin
								push_action(ACT_NEED, 8'h00);
								prd_phase = PH_WNEED;
							end else begin
								push_action(ACT_START, 8'h00);
								prd_phase = PH_REP;
							end
						end
						PH_REP: begin
							push_action(ACT_SEND, dev | 8'h01);
							prd_phase = PH_DEVR;
						end
						PH_DEVR: begin
							if (prd_total == 16'd0) begin
								push_action(ACT_STOP, 8'h00);
								push_action(ACT_OK, 8'h00);
								prd_phase = PH_IDLE;
							end else begin
								push_action(final_read_next() ? ACT_RNACK : ACT_RACK, 8'h00);
								prd_phase = PH_RDATA;
							end
						end
						PH_RDATA: begin
							push_action(ACT_DATA, rb);
							prd_done = prd_done + 16'd1;
							prd_addr = prd_addr + 16'd1;
							if (prd_done >= prd_total) begin
								push_action(ACT_STOP, 8'h00);
								push_action(ACT_OK, 8'h00);
								prd_phase = PH_IDLE;
							end else begin
								push_action(final_read_next() ? ACT_RNACK : ACT_RACK, 8'h00);
							end
						end
						default: begin
							// PH_WDATA: byte acked, maybe close the page
							prd_addr = prd_addr + 16'd1;
							prd_done = prd_done + 16'd1;
							if (prd_done >= prd_total) begin
								push_action(ACT_STOP, 8'h00);
								push_action(ACT_WAIT, cfg_wait);
								push_action(ACT_OK, 8'h00);
								prd_phase = PH_IDLE;
							end else if ((int'(prd_addr) % PAGE_BYTES) == 0) begin
								push_action(ACT_STOP, 8'h00);
								push_action(ACT_WAIT, cfg_wait);
								push_action(ACT_START, 8'h00);
								prd_phase = PH_START;
							end else begin
								push_action(ACT_NEED, 8'h00);
								prd_phase = PH_WNEED;
							end
						end
					endcase
				end
			end
			default: begin
				if (prd_phase == PH_WNEED) begin
					push_action(ACT_SEND, wb);
					prd_phase = PH_WDATA;
				end
			end
		endcase
		if (pending_actions.size() > first)
			pending_actions[pending_actions.size() - 1].last = 1'b1;
		return pending_actions.size() - first;
	endfunction

	// one transfer on the request channel; valid stays high on return
	task automatic send_item(op_t op, logic [15:0] addr, logic [15:0] len, st_t st,
			logic [7:0] rb, logic [7:0] wb);
		if (!no_idle && $urandom_range(0, 99) < 6) begin
			req_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(posedge clk);
		end
		req_ch.valid       <= 1'b1;
		req_ch.opcode      <= op;
		req_ch.mem_address <= addr;
		req_ch.length      <= len;
		req_ch.bus_status  <= st;
		req_ch.read_byte   <= rb;
		req_ch.write_byte  <= wb;
		@(posedge clk);
		while (!req_ch.ready)
			@(posedge clk);
		items_sent++;
		results_of_last = predict_actions(op, addr, len, st, rb, wb);
	endtask

	task automatic send_status(st_t st, logic [7:0] rb);
		send_item(OP_STATUS, 16'h0000, 16'h0000, st, rb, 8'h00);
	endtask

	task automatic send_begin(op_t op, logic [15:0] addr, logic [15:0] len);
		send_item(op, addr, len, ST_OTHER, 8'h00, 8'h00);
	endtask

	task automatic send_host_byte(logic [7:0] wb);
		send_item(OP_WBYTE, 16'h0000, 16'h0000, ST_OTHER, 8'h00, wb);
	endtask

	task automatic drain();
		req_ch.valid <= 1'b0;
		for (int i = 0; i < DRAIN_LIMIT && pending_actions.size() != 0; i++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// close any open transfer with a bad reply, then wait for the block to go quiet
	task automatic settle();
		if (prd_phase != PH_IDLE)
			send_status(ST_OTHER, 8'h00);
		drain();
	endtask

	task automatic program_registers(logic [6:0] dev, logic [7:0] wms);
		settle();
		cfg_we    <= 1'b1;
		cfg_index <= REG_DEVICE_ADDRESS;
		cfg_data  <= {1'b0, dev};
		@(posedge clk);
		cfg_index <= REG_WRITE_WAIT_MS;
		cfg_data  <= wms;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_dev = dev;
		cfg_wait = wms;
	endtask

	// mostly the reply the block is waiting for, sometimes noise
	task automatic send_random_item();
		op_t         op;
		logic [15:0] a;
		logic [15:0] l;
		st_t         st;
		logic [7:0]  rb;
		logic [7:0]  wb;
		int          pick;
		a = $urandom;
		l = $urandom;
		st = st_t'($urandom_range(0, 7));
		rb = $urandom;
		wb = $urandom;
		op = op_t'($urandom_range(0, 3));
		pick = $urandom_range(0, 99);
		if (prd_phase == PH_IDLE) begin
			if (pick < 85) begin
				op = $urandom_range(0, 1) ? OP_WR : OP_RD;
				case ($urandom_range(0, 9))
					0, 1, 2, 3, 4, 5, 6: l = $urandom_range(0, 6);
					7, 8:                l = $urandom_range(7, 80);
					default:             ;
				endcase
				// land near the end of a page so writes cross it
				if ($urandom_range(0, 2) == 0)
					a = (a | 16'(PAGE_BYTES - 1)) - 16'($urandom_range(0, 3));
			end
		end else if (pick < 94) begin
			if (prd_phase == PH_WNEED) begin
				op = OP_WBYTE;
			end else begin
				op = OP_STATUS;
				st = wanted_status();
			end
		end
		send_item(op, a, l, st, rb, wb);
	endtask

	task automatic test_random(int n);
		int taken;
		taken = 0;
		while (taken < n) begin
			send_random_item();
			if (results_of_last > 0)
				taken++;
		end
	endtask

	task automatic test_ignored_items();
		send_status(ST_START, 8'hFF);
		send_host_byte(8'hFF);
	endtask

	task automatic test_zero_length_write();
		send_begin(OP_WR, 16'hFFFF, 16'h0000);
	endtask

	task automatic test_read_ack_nack();
		send_begin(OP_RD, 16'h0000, 16'd2);
		send_begin(OP_WR, 16'hFFFF, 16'hFFFF);	// busy: dropped
		send_status(ST_START, 8'h00);
		send_status(ST_TXADDR, 8'h00);
		send_status(ST_TXDATA, 8'h00);
		send_status(ST_TXDATA, 8'h00);
		send_status(ST_REP, 8'h00);
		send_status(ST_RXADDR, 8'h00);
		send_status(ST_RXACK, 8'hFF);
		send_status(ST_RXNACK, 8'h00);
	endtask

	task automatic test_zero_length_read();
		send_begin(OP_RD, 16'h8000, 16'h0000);
		send_status(ST_START, 8'h00);
		send_status(ST_TXADDR, 8'h00);
		send_status(ST_TXDATA, 8'h00);
		send_status(ST_TXDATA, 8'h00);
		send_status(ST_REP, 8'h00);
		send_status(ST_RXADDR, 8'h00);
	endtask

	// top address: first byte closes the page and the address wraps to zero;
	// ends with a bus reply while a host byte is outstanding
	task automatic test_page_wrap_write();
		send_begin(OP_WR, 16'hFFFF, 16'd3);
		send_host_byte(8'h5A);	// not requested yet: dropped
		send_status(ST_START, 8'h00);
		send_status(ST_TXADDR, 8'h00);
		send_status(ST_TXDATA, 8'h00);
		send_status(ST_TXDATA, 8'h00);
		send_host_byte(8'hFF);
		send_status(ST_TXDATA, 8'h00);
		send_status(ST_START, 8'h00);
		send_status(ST_TXADDR, 8'h00);
		send_status(ST_TXDATA, 8'h00);
		send_status(ST_TXDATA, 8'h00);
		send_host_byte(8'h00);
		send_status(ST_TXDATA, 8'h00);
		send_status(ST_TXDATA, 8'h00);
	endtask

	task automatic test_bad_status();
		send_begin(OP_RD, 16'h1234, 16'hFFFF);
		send_status(ST_OTHER, 8'h00);
	endtask

	// receiver stalls while requests keep coming, so the queue fills and req backs up
	task automatic test_result_backpressure();
		-> hold_kick;
		test_random(30);
		drain();
	endtask

	// result checker and receiver-side ready
	initial begin
		bus_action_t want;
		rsp_ch.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
				results_checked++;
				if (pending_actions.size() == 0) begin
					flag_error($sformatf("unexpected result: action %0d byte %02h last %0b",
						rsp_ch.action, rsp_ch.out_byte, rsp_ch.last));
				end else begin
					want = pending_actions.pop_front();
					if (rsp_ch.action !== want.action || rsp_ch.out_byte !== want.out_byte ||
							rsp_ch.last !== want.last)
						flag_error($sformatf(
							"result %0d: expected action %0d byte %02h last %0b, got %0d %02h %0b",
							results_checked, want.action, want.out_byte, want.last,
							rsp_ch.action, rsp_ch.out_byte, rsp_ch.last));
				end
			end
			rsp_ch.ready <= !hold_active && (no_idle || $urandom_range(0, 99) >= 6);
		end
	end

	initial begin
		forever begin
			@(hold_kick);
			@(posedge clk);
			hold_active <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			hold_active <= 1'b0;
		end
	end

	initial begin
		#(RUN_LIMIT);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin
		req_ch.valid       <= 1'b0;
		req_ch.opcode      <= OP_RD;
		req_ch.mem_address <= '0;
		req_ch.length      <= '0;
		req_ch.bus_status  <= ST_START;
		req_ch.read_byte   <= '0;
		req_ch.write_byte  <= '0;
		cfg_we    <= 1'b0;
		cfg_index <= REG_DEVICE_ADDRESS;
		cfg_data  <= '0;
		prd_phase = PH_IDLE;
		prd_writing = 1'b0;
		prd_addr = '0;
		prd_done = '0;
		prd_total = '0;
		cfg_dev = DEV_ADDR_RST;
		cfg_wait = WAIT_MS_RST;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// directed part runs on the reset register values
		test_ignored_items();
		test_zero_length_write();
		test_read_ack_nack();
		test_zero_length_read();
		test_page_wrap_write();
		test_bad_status();

		program_registers(7'd0, 8'd0);
		test_random(85);
		program_registers(7'd127, 8'd255);
		test_result_backpressure();
		program_registers(7'($urandom), 8'($urandom));
		no_idle = 1'b1;
		test_random(85);
		settle();
		no_idle = 1'b0;
		program_registers(7'($urandom), 8'($urandom));
		test_random(90);
		settle();

		if (pending_actions.size() != 0)
			flag_error($sformatf("%0d expected results never arrived", pending_actions.size()));
		$display("Sent %0d requests, checked %0d results; %0d transfers begun, %0d bus errors.",
			items_sent, results_checked, begins_taken, bus_errors);
		$display("Register sets: reset, both extremes and random; one long result stall.");
		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule
